### sv/gtr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_pkg
// Shared types, constants, font ROM and saturation helper for the glyph
// text rasteriser.
// ----------------------------------------------------------------------------
package gtr_pkg;

   localparam int GLYPH_COUNT   = 96;
   localparam int GLYPH_COLS    = 5;
   localparam int GLYPH_ROWS    = 7;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [7:0] FIRST_CODE   = 8'd32;
   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [2:0] ADVANCE_CELLS = 3'd6;
   localparam logic [3:0] LINE_CELLS    = 4'd8;

   localparam logic signed [17:0] SAT_MAX = 18'sd32767;
   localparam logic signed [17:0] SAT_MIN = -18'sd32768;

   // One glyph job: lit pixels per column plus the snapshot of the pen.
   typedef logic [GLYPH_ROWS-1:0] glyph_col_type;

   typedef struct packed {
      glyph_col_type [GLYPH_COLS-1:0] mask;
      logic signed [15:0]             base_x;
      logic signed [15:0]             base_y;
      logic [3:0]                     scale;
      logic [31:0]                    color;
   } glyph_job_type;

   // Font ROM: column 0 in the top byte, column 4 in the bottom byte.
   localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
      40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
      40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
      40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
      40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
      40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
      40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h18A4A4A47C,
      40'h7F08040478, 40'h00447D4000, 40'h4080847D00, 40'h7F10284400,
      40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
      40'hFC24242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545420,
      40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
      40'h4428102844, 40'h1CA0A0A07C, 40'h4464544C44, 40'h0008364100,
      40'h00007F0000, 40'h0041360800, 40'h1008081008, 40'h0000000000
   };

   // Clamp an extended sum to the signed 16-bit range.
   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > SAT_MAX) begin
         r = 16'sh7FFF;
      end else if (v < SAT_MIN) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

### sv/gtr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_queue
// Short job queue between the character front end and the square emitter.
// ----------------------------------------------------------------------------
module gtr_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  gtr_pkg::glyph_job_type push_data,
   output logic                   full,
   input  logic                   pop,
   output logic                   not_empty,
   output gtr_pkg::glyph_job_type pop_data
);
   import gtr_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   glyph_job_type      slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;

   // Status flags come straight from the fill count.
   assign full      = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   // Pointer and count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage slots need no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/gtr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_front
// Accepts text bytes, tracks the pen and turns drawable glyphs into jobs.
// ----------------------------------------------------------------------------
module gtr_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_char_code,
   input  logic                   req_first,
   input  logic signed [15:0]     req_start_x,
   input  logic signed [15:0]     req_start_y,
   input  logic [3:0]             req_scale_in,
   input  logic [31:0]            req_color_in,
   input  logic                   queue_full,
   output logic                   job_push,
   output gtr_pkg::glyph_job_type job_data
);
   import gtr_pkg::*;

   logic signed [15:0] cursor_x_ff, cursor_x_in;
   logic signed [15:0] cursor_y_ff, cursor_y_in;
   logic signed [15:0] line_start_x_ff, line_start_x_in;
   logic [3:0]         pixel_scale_ff, pixel_scale_in;
   logic [31:0]        draw_color_ff, draw_color_in;

   logic               accept;
   logic signed [15:0] eff_x, eff_y, eff_line_x;
   logic [3:0]         eff_scale;
   logic [31:0]        eff_color;
   logic               is_newline, is_drawable, has_pixels;
   logic [6:0]         glyph_idx;
   logic [39:0]        rom_word;
   logic [6:0]         advance, line_step;
   glyph_col_type [GLYPH_COLS-1:0] mask;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Settings in force for this byte: a first byte overrides the latched ones.
   always_comb begin
      if (req_first) begin
         eff_x      = req_start_x;
         eff_y      = req_start_y;
         eff_line_x = req_start_x;
         eff_scale  = (req_scale_in == 4'd0) ? 4'd1 : req_scale_in;
         eff_color  = req_color_in;
      end else begin
         eff_x      = cursor_x_ff;
         eff_y      = cursor_y_ff;
         eff_line_x = line_start_x_ff;
         eff_scale  = pixel_scale_ff;
         eff_color  = draw_color_ff;
      end
   end

   // Classify the byte and fetch its columns from the font ROM.
   always_comb begin
      is_newline  = (req_char_code == NEWLINE_CODE);
      is_drawable = (req_char_code[7] == 1'b0) && (req_char_code[6:5] != 2'b00);
      glyph_idx   = req_char_code[6:0] - FIRST_CODE[6:0];
      rom_word    = is_drawable ? GLYPH_ROM[glyph_idx] : 40'h0;
      for (int c = 0; c < GLYPH_COLS; c++) begin
         mask[c] = rom_word[(GLYPH_COLS-1-c)*8 +: GLYPH_ROWS];
      end
      has_pixels  = (mask != '0);
   end

   // Pen movement.
   always_comb begin
      advance         = 7'(eff_scale) * 7'(ADVANCE_CELLS);
      line_step       = 7'(eff_scale) * 7'(LINE_CELLS);
      cursor_x_in     = cursor_x_ff;
      cursor_y_in     = cursor_y_ff;
      line_start_x_in = line_start_x_ff;
      pixel_scale_in  = pixel_scale_ff;
      draw_color_in   = draw_color_ff;
      if (accept) begin
         line_start_x_in = eff_line_x;
         pixel_scale_in  = eff_scale;
         draw_color_in   = eff_color;
         if (is_newline) begin
            cursor_x_in = eff_line_x;
            cursor_y_in = sat16(18'(eff_y) + 18'(line_step));
         end else begin
            cursor_x_in = sat16(18'(eff_x) + 18'(advance));
            cursor_y_in = eff_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff     <= '0;
         cursor_y_ff     <= '0;
         line_start_x_ff <= '0;
         pixel_scale_ff  <= 4'd1;
         draw_color_ff   <= '0;
      end else begin
         cursor_x_ff     <= cursor_x_in;
         cursor_y_ff     <= cursor_y_in;
         line_start_x_ff <= line_start_x_in;
         pixel_scale_ff  <= pixel_scale_in;
         draw_color_ff   <= draw_color_in;
      end
   end

   // Only glyphs with at least one lit pixel become jobs.
   always_comb begin
      job_push        = accept && has_pixels;
      job_data.mask   = mask;
      job_data.base_x = eff_x;
      job_data.base_y = eff_y;
      job_data.scale  = eff_scale;
      job_data.color  = eff_color;
   end

endmodule

### sv/gtr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_back
// Walks the lit pixels of one glyph job and emits one square per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module gtr_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   input  gtr_pkg::glyph_job_type job_data,
   output logic                   job_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [15:0]     rsp_rect_x,
   output logic signed [15:0]     rsp_rect_y,
   output logic [3:0]             rsp_rect_size,
   output logic [31:0]            rsp_rect_color,
   output logic                   rsp_last
);
   import gtr_pkg::*;

   logic          busy_ff, busy_in;
   glyph_job_type job_ff, job_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rect_x_ff, rect_x_in;
   logic signed [15:0] rect_y_ff, rect_y_in;
   logic [3:0]         rect_size_ff, rect_size_in;
   logic [31:0]        rect_color_ff, rect_color_in;
   logic               last_ff, last_in;

   logic       out_free, emit, col_found;
   logic [2:0] col_sel, row_sel;
   logic [6:0] col_off, row_off;
   glyph_col_type [GLYPH_COLS-1:0] mask_after;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = busy_ff && out_free;
   assign job_pop  = !busy_ff && job_valid;

   // Lowest lit column first, then lowest lit row within it.
   always_comb begin
      col_sel   = '0;
      row_sel   = '0;
      col_found = 1'b0;
      for (int c = 0; c < GLYPH_COLS; c++) begin
         if (!col_found && job_ff.mask[c] != '0) begin
            col_found = 1'b1;
            col_sel   = 3'(c);
         end
      end
      for (int r = GLYPH_ROWS-1; r >= 0; r--) begin
         if (job_ff.mask[col_sel][r]) begin
            row_sel = 3'(r);
         end
      end
      mask_after                   = job_ff.mask;
      mask_after[col_sel][row_sel] = 1'b0;
   end

   // Square position from the pen snapshot.
   always_comb begin
      col_off       = 7'(col_sel) * 7'(job_ff.scale);
      row_off       = 7'(row_sel) * 7'(job_ff.scale);
      rect_x_in     = rect_x_ff;
      rect_y_in     = rect_y_ff;
      rect_size_in  = rect_size_ff;
      rect_color_in = rect_color_ff;
      last_in       = last_ff;
      if (emit) begin
         rect_x_in     = sat16(18'(job_ff.base_x) + 18'(col_off));
         rect_y_in     = sat16(18'(job_ff.base_y) + 18'(row_off));
         rect_size_in  = job_ff.scale;
         rect_color_in = job_ff.color;
         last_in       = (mask_after == '0);
      end
   end

   // Job register and output valid.
   always_comb begin
      busy_in = busy_ff;
      job_in  = job_ff;
      if (job_pop) begin
         busy_in = 1'b1;
         job_in  = job_data;
      end else if (emit) begin
         job_in.mask = mask_after;
         busy_in     = (mask_after != '0);
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      rect_x_ff     <= rect_x_in;
      rect_y_ff     <= rect_y_in;
      rect_size_ff  <= rect_size_in;
      rect_color_ff <= rect_color_in;
      last_ff       <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rect_x     = rect_x_ff;
   assign rsp_rect_y     = rect_y_ff;
   assign rsp_rect_size  = rect_size_ff;
   assign rsp_rect_color = rect_color_ff;
   assign rsp_last       = last_ff;

endmodule

### sv/glyph_text_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_text_rasterizer
// 5x7 font character generator that turns text bytes into filled squares.
// ----------------------------------------------------------------------------
// The front end takes one byte per cycle while the job queue has room,
// updates the pen at once and hands each glyph with lit pixels to a
// two-entry queue. The square emitter then produces one square per cycle
// while the output is not stalled, one per lit pixel, column by column and
// top row first, and loads the next job only after the current one is done.
// Newline, blank and non-printing bytes are taken by the front end and
// give no squares. The emitter is the rate limit for sustained text.
module glyph_text_rasterizer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_char_code,
   input  logic               req_first,
   input  logic signed [15:0] req_start_x,
   input  logic signed [15:0] req_start_y,
   input  logic [3:0]         req_scale_in,
   input  logic [31:0]        req_color_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_rect_x,
   output logic signed [15:0] rsp_rect_y,
   output logic [3:0]         rsp_rect_size,
   output logic [31:0]        rsp_rect_color,
   output logic               rsp_last
);
   import gtr_pkg::*;

   logic          queue_full, job_push, job_pop, job_valid;
   glyph_job_type push_job, pop_job;

   // Byte intake and pen tracking.
   gtr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_first     (req_first),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_scale_in  (req_scale_in),
      .req_color_in  (req_color_in),
      .queue_full    (queue_full),
      .job_push      (job_push),
      .job_data      (push_job)
   );

   // Glyph jobs waiting for the emitter.
   gtr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_job),
      .full      (queue_full),
      .pop       (job_pop),
      .not_empty (job_valid),
      .pop_data  (pop_job)
   );

   // Square emission.
   gtr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (job_valid),
      .job_data       (pop_job),
      .job_pop        (job_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_rect_x     (rsp_rect_x),
      .rsp_rect_y     (rsp_rect_y),
      .rsp_rect_size  (rsp_rect_size),
      .rsp_rect_color (rsp_rect_color),
      .rsp_last       (rsp_last)
   );

endmodule
